// ===== sv/packet_send_pacer_assert.svh =====
// Assertion macros shared by the pacer RTL.
// Both sample on the rising edge of clk and are switched off while rst_n is low.
`ifndef PACKET_SEND_PACER_ASSERT_SVH
`define PACKET_SEND_PACER_ASSERT_SVH

// Checks the consequent in the same cycle as the antecedent.
`define PSP_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pacer assertion failed");

// Checks the consequent in the cycle after the antecedent.
`define PSP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pacer assertion failed");

`endif

// ===== sv/ppace_pkg.sv =====
package ppace_pkg;

  localparam int TIME_BITS   = 48;
  localparam int QUEUE_SLOTS = 32;
  localparam int CNT_W       = 6;
  localparam int IVL_W       = 32;
  localparam int SPD_W       = 5;
  localparam int LAG_W       = IVL_W + SPD_W;
  localparam int ADD_W       = ((TIME_BITS > LAG_W) ? TIME_BITS : LAG_W) + 1;
  localparam int DIV_STEPS   = IVL_W / 2;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS);
  localparam int TDATA_W     = ((TIME_BITS + CNT_W + 7) / 8) * 8;
  localparam int ADDR_W      = 4;
  localparam int DATA_W      = 32;

  typedef logic [TIME_BITS-1:0] time_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [IVL_W-1:0]     ivl_t;
  typedef logic [SPD_W-1:0]     spd_t;
  typedef logic [LAG_W-1:0]     lag_t;
  typedef logic [ADD_W-1:0]     add_t;
  typedef logic [DATA_W-1:0]    data_t;

  localparam cnt_t DEPTH_MAX = cnt_t'(QUEUE_SLOTS);

  // Register indexes (paddr[3:2]).
  localparam logic [1:0] REG_PACE_INTERVAL = 2'd0;
  localparam logic [1:0] REG_CATCHUP_DEPTH = 2'd1;
  localparam logic [1:0] REG_IVL_DIVISOR   = 2'd2;
  localparam logic [1:0] REG_MAX_LAG_SENDS = 2'd3;

  localparam logic ACT_CHECK    = 1'b0;
  localparam logic ACT_REANCHOR = 1'b1;

  typedef struct packed {
    ivl_t pace_interval;
    cnt_t catchup_depth;
    spd_t ivl_divisor;
    spd_t max_lag_sends;
  } cfg_t;

  typedef struct packed {
    cnt_t  send_count;
    logic  catchup_active;
    time_t next_deadline;
  } res_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_CATCH,
    ST_MUL,
    ST_SUB,
    ST_CLAMP,
    ST_STEP,
    ST_DONE
  } state_t;

endpackage

// ===== sv/ppace_div.sv =====
// Radix-4 restoring divider: two quotient bits per cycle.
module ppace_div (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  ppace_pkg::ivl_t   dividend,
  input  ppace_pkg::spd_t   divisor,
  output logic              done,
  output ppace_pkg::ivl_t   quotient
);

  ppace_pkg::ivl_t                       q_r, q_nxt;
  ppace_pkg::spd_t                       rem_r, rem_nxt;
  ppace_pkg::spd_t                       dvs_r, dvs_nxt;
  logic [ppace_pkg::DIV_CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                                  busy_r, busy_nxt;
  logic                                  done_r, done_nxt;
  logic [ppace_pkg::SPD_W:0]             r1, r2;
  logic [ppace_pkg::SPD_W-1:0]           rem1;
  logic                                  qb1, qb2;

  always_comb begin
    r1  = {rem_r, q_r[ppace_pkg::IVL_W-1]};
    qb1 = (r1 >= {1'b0, dvs_r});
    rem1 = qb1 ? ppace_pkg::spd_t'(r1 - {1'b0, dvs_r}) : ppace_pkg::spd_t'(r1);
    r2  = {rem1, q_r[ppace_pkg::IVL_W-2]};
    qb2 = (r2 >= {1'b0, dvs_r});
  end

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = done_r;
    if (start) begin
      q_nxt    = dividend;
      rem_nxt  = '0;
      dvs_nxt  = (divisor == '0) ? ppace_pkg::spd_t'(1) : divisor;
      cnt_nxt  = ppace_pkg::DIV_CNT_W'(ppace_pkg::DIV_STEPS - 1);
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
    end else if (busy_r) begin
      q_nxt   = {q_r[ppace_pkg::IVL_W-3:0], qb1, qb2};
      rem_nxt = qb2 ? ppace_pkg::spd_t'(r2 - {1'b0, dvs_r}) : ppace_pkg::spd_t'(r2);
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    cnt_r <= cnt_nxt;
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

// ===== sv/ppace_core.sv =====
// Sequencer around one shared adder and one shared comparator.
module ppace_core (
  input  logic              clk,
  input  logic              rst_n,
  input  ppace_pkg::cfg_t   cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_action,
  input  ppace_pkg::time_t  in_now,
  input  ppace_pkg::cnt_t   in_depth,
  output logic              res_valid,
  input  logic              res_ready,
  output ppace_pkg::res_t   res
);

  ppace_pkg::state_t state_r, state_nxt;
  logic              action_r, action_nxt;
  ppace_pkg::time_t  now_r, now_nxt;
  ppace_pkg::cnt_t   depth_r, depth_nxt;
  ppace_pkg::time_t  dl_r, dl_nxt;
  ppace_pkg::cnt_t   sent_r, sent_nxt;
  logic              catch_r, catch_nxt;
  ppace_pkg::lag_t   lag_r, lag_nxt;
  ppace_pkg::time_t  earliest_r, earliest_nxt;

  ppace_pkg::add_t   add_a, add_b, add_sum;
  logic              add_cin;
  ppace_pkg::time_t  add_sat;
  ppace_pkg::time_t  cmp_a, cmp_b;
  logic              cmp_ge;
  logic              div_start, div_done;
  ppace_pkg::ivl_t   div_q;
  logic              ivl_zero, in_catch, step_go;

  ppace_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (cfg.pace_interval),
    .divisor  (cfg.ivl_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  // Shared adder; a sum beyond the time range saturates.
  assign add_sum = add_a + add_b + ppace_pkg::add_t'(add_cin);
  assign add_sat = (|add_sum[ppace_pkg::ADD_W-1:ppace_pkg::TIME_BITS]) ? '1
                 : add_sum[ppace_pkg::TIME_BITS-1:0];
  assign cmp_ge  = (cmp_a >= cmp_b);

  assign ivl_zero = (cfg.pace_interval == '0);
  assign in_catch = (depth_r >= cfg.catchup_depth);
  assign step_go  = cmp_ge && (sent_r < depth_r);

  // Operand selection for the shared units.
  always_comb begin
    add_a   = ppace_pkg::add_t'(dl_r);
    add_b   = ppace_pkg::add_t'(cfg.pace_interval);
    add_cin = 1'b0;
    cmp_a   = now_r;
    cmp_b   = dl_r;
    case (state_r)
      ppace_pkg::ST_CATCH: begin
        add_a = ppace_pkg::add_t'(now_r);
        add_b = ppace_pkg::add_t'(div_q);
      end
      ppace_pkg::ST_SUB: begin
        add_a   = ppace_pkg::add_t'(now_r);
        add_b   = ~ppace_pkg::add_t'(lag_r);
        add_cin = 1'b1;
      end
      ppace_pkg::ST_CLAMP: begin
        cmp_a = dl_r;
        cmp_b = earliest_r;
      end
      default: begin
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ppace_pkg::ST_IDLE:  if (in_valid) state_nxt = ppace_pkg::ST_CHECK;
      ppace_pkg::ST_CHECK: begin
        if (action_r == ppace_pkg::ACT_REANCHOR || ivl_zero) begin
          state_nxt = ppace_pkg::ST_DONE;
        end else if (in_catch) begin
          state_nxt = (cmp_ge && depth_r != '0) ? ppace_pkg::ST_DIV : ppace_pkg::ST_DONE;
        end else begin
          state_nxt = cmp_ge ? ppace_pkg::ST_MUL : ppace_pkg::ST_DONE;
        end
      end
      ppace_pkg::ST_DIV:   if (div_done) state_nxt = ppace_pkg::ST_CATCH;
      ppace_pkg::ST_CATCH: state_nxt = ppace_pkg::ST_DONE;
      ppace_pkg::ST_MUL:   state_nxt = ppace_pkg::ST_SUB;
      ppace_pkg::ST_SUB:   state_nxt = ppace_pkg::ST_CLAMP;
      ppace_pkg::ST_CLAMP: state_nxt = ppace_pkg::ST_STEP;
      ppace_pkg::ST_STEP:  state_nxt = step_go ? ppace_pkg::ST_STEP : ppace_pkg::ST_DONE;
      ppace_pkg::ST_DONE:  if (res_ready) state_nxt = ppace_pkg::ST_IDLE;
      default:             state_nxt = ppace_pkg::ST_IDLE;
    endcase
  end

  // Datapath updates.
  always_comb begin
    action_nxt   = action_r;
    now_nxt      = now_r;
    depth_nxt    = depth_r;
    dl_nxt       = dl_r;
    sent_nxt     = sent_r;
    catch_nxt    = catch_r;
    lag_nxt      = lag_r;
    earliest_nxt = earliest_r;
    div_start    = 1'b0;
    case (state_r)
      ppace_pkg::ST_IDLE: begin
        if (in_valid) begin
          action_nxt = in_action;
          now_nxt    = in_now;
          depth_nxt  = (in_depth > ppace_pkg::DEPTH_MAX) ? ppace_pkg::DEPTH_MAX : in_depth;
          sent_nxt   = '0;
          catch_nxt  = 1'b0;
        end
      end
      ppace_pkg::ST_CHECK: begin
        if (action_r == ppace_pkg::ACT_REANCHOR) begin
          dl_nxt = now_r;
        end else if (ivl_zero) begin
          sent_nxt = depth_r;
        end else if (in_catch) begin
          catch_nxt = 1'b1;
          div_start = cmp_ge && (depth_r != '0);
        end
      end
      ppace_pkg::ST_CATCH: begin
        dl_nxt   = add_sat;
        sent_nxt = ppace_pkg::cnt_t'(1);
      end
      ppace_pkg::ST_MUL: begin
        lag_nxt = ppace_pkg::lag_t'(cfg.pace_interval) * ppace_pkg::lag_t'(cfg.max_lag_sends);
      end
      ppace_pkg::ST_SUB: begin
        // The top bit of the difference is set when the lag reaches past time zero.
        earliest_nxt = add_sum[ppace_pkg::ADD_W-1] ? '0 : add_sum[ppace_pkg::TIME_BITS-1:0];
      end
      ppace_pkg::ST_CLAMP: begin
        if (!cmp_ge) dl_nxt = earliest_r;
      end
      ppace_pkg::ST_STEP: begin
        if (step_go) begin
          sent_nxt = sent_r + 1'b1;
          dl_nxt   = add_sat;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ppace_pkg::ST_IDLE;
      dl_r    <= '0;
    end else begin
      state_r <= state_nxt;
      dl_r    <= dl_nxt;
    end
    action_r   <= action_nxt;
    now_r      <= now_nxt;
    depth_r    <= depth_nxt;
    sent_r     <= sent_nxt;
    catch_r    <= catch_nxt;
    lag_r      <= lag_nxt;
    earliest_r <= earliest_nxt;
  end

  assign in_ready               = (state_r == ppace_pkg::ST_IDLE);
  assign res_valid              = (state_r == ppace_pkg::ST_DONE);
  assign res.send_count         = sent_r;
  assign res.catchup_active     = catch_r;
  assign res.next_deadline      = dl_r;

endmodule

// ===== sv/packet_send_pacer.sv =====
// Channel  | Direction | Contents
// in_      | input     | tuser: action; tdata: now_time, queue_depth
// out_     | output    | tuser: catchup_active; tdata: send_count, next_deadline
// cfg_     | input     | APB-style register port, four registers on a 32-bit bus
//
// Flow: one transaction at a time. A re-anchor, a zero interval or a deadline
// not yet reached goes from CHECK straight to DONE. The catch-up path waits
// in DIV for the radix-4 divider that forms the shortened interval, then
// sets the deadline in CATCH. The paced path runs MUL, SUB and CLAMP, then
// stays in STEP while packets are released; the shared adder advances the
// deadline once a cycle.
// Reset: synchronous, active low; the state, the configuration registers and
// the output valid return to their reset values and the send deadline to zero.
// Stalls: a result waits in the output register while out_tready is low; a
// following transaction is still accepted and worked on meanwhile.
module packet_send_pacer (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [ppace_pkg::TDATA_W-1:0]  in_tdata,   // [47:0] now_time, [53:48] queue_depth
  input  logic                           in_tuser,   // [0] action
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [ppace_pkg::TDATA_W-1:0]  out_tdata,  // [5:0] send_count, [53:6] next_deadline
  output logic                           out_tuser,  // [0] catchup_active
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [ppace_pkg::ADDR_W-1:0]   cfg_paddr,
  input  logic [ppace_pkg::DATA_W-1:0]   cfg_pwdata,
  output logic [ppace_pkg::DATA_W-1:0]   cfg_prdata,
  output logic                           cfg_pready
);

  `include "packet_send_pacer_assert.svh"

  // Configuration registers.
  ppace_pkg::cfg_t  cfg_r, cfg_nxt;
  logic             cfg_wr;
  logic [1:0]       cfg_idx;

  // Output register between the core and the result channel.
  logic             out_valid_r, out_valid_nxt;
  ppace_pkg::res_t  out_res_r, out_res_nxt;

  logic             res_valid, res_ready;
  ppace_pkg::res_t  res;
  ppace_pkg::time_t in_now;
  ppace_pkg::cnt_t  in_depth;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = cfg_paddr[3:2];

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      case (cfg_idx)
        ppace_pkg::REG_PACE_INTERVAL:
          cfg_nxt.pace_interval = cfg_pwdata[ppace_pkg::IVL_W-1:0];
        ppace_pkg::REG_CATCHUP_DEPTH:
          cfg_nxt.catchup_depth = cfg_pwdata[ppace_pkg::CNT_W-1:0];
        ppace_pkg::REG_IVL_DIVISOR:
          cfg_nxt.ivl_divisor = cfg_pwdata[ppace_pkg::SPD_W-1:0];
        ppace_pkg::REG_MAX_LAG_SENDS:
          cfg_nxt.max_lag_sends = cfg_pwdata[ppace_pkg::SPD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Reads return the register zero-extended to the bus width.
  always_comb begin
    case (cfg_idx)
      ppace_pkg::REG_PACE_INTERVAL: cfg_prdata = ppace_pkg::data_t'(cfg_r.pace_interval);
      ppace_pkg::REG_CATCHUP_DEPTH: cfg_prdata = ppace_pkg::data_t'(cfg_r.catchup_depth);
      ppace_pkg::REG_IVL_DIVISOR:   cfg_prdata = ppace_pkg::data_t'(cfg_r.ivl_divisor);
      ppace_pkg::REG_MAX_LAG_SENDS: cfg_prdata = ppace_pkg::data_t'(cfg_r.max_lag_sends);
      default:                      cfg_prdata = '0;
    endcase
  end

  assign in_now   = in_tdata[ppace_pkg::TIME_BITS-1:0];
  assign in_depth = in_tdata[ppace_pkg::TIME_BITS +: ppace_pkg::CNT_W];

  ppace_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_action (in_tuser),
    .in_now    (in_now),
    .in_depth  (in_depth),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // The core hands over a result whenever the output register is empty or is
  // being emptied in the same cycle.
  assign res_ready = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = res;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pace_interval <= '0;
      cfg_r.catchup_depth <= ppace_pkg::cnt_t'(8);
      cfg_r.ivl_divisor   <= ppace_pkg::spd_t'(2);
      cfg_r.max_lag_sends <= ppace_pkg::spd_t'(2);
      out_valid_r         <= 1'b0;
    end else begin
      cfg_r       <= cfg_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_res_r <= out_res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.catchup_active;
  assign out_tdata  = ppace_pkg::TDATA_W'({out_res_r.next_deadline, out_res_r.send_count});

  // The block works on one transaction at a time.
  `PSP_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready)
  // The catch-up path releases at most one packet.
  `PSP_ASSERT_SAME(a_catchup_single, out_tvalid && out_tuser, out_tdata[5:0] <= 6'd1)
  // No more packets are released than the queue can hold.
  `PSP_ASSERT_SAME(a_count_bounded, out_tvalid, out_tdata[5:0] <= ppace_pkg::DEPTH_MAX)

endmodule

// ===== test/pacer_monitor.sv =====
module pacer_monitor
  import ppace_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  input  logic               in_tready,
  input  logic [TDATA_W-1:0] in_tdata,     // [47:0] now_time, [53:48] queue_depth
  input  logic               in_tuser,     // [0] action
  input  logic               out_tvalid,
  input  logic               out_tready,
  input  logic [TDATA_W-1:0] out_tdata,    // [5:0] send_count, [53:6] next_deadline
  input  logic               out_tuser,    // [0] catchup_active
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic               cfg_pready,
  input  logic [ADDR_W-1:0]  cfg_paddr,
  input  logic [DATA_W-1:0]  cfg_pwdata,
  output int                 errors,
  output int                 pending,
  output int                 results_seen,
  output int                 catchup_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] LAST_TICK = (64'd1 << TIME_BITS) - 64'd1;

  // Own copy of the register file and of the send deadline.
  ivl_t  interval;
  cnt_t  catch_depth;
  spd_t  speedup;
  spd_t  lag_sends;
  time_t deadline;

  res_t  due_results[$];

  // Deadline sums never pass the largest time value.
  function automatic logic [63:0] capped_sum(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] s;
    s = a + b;
    return (s > LAST_TICK) ? LAST_TICK : s;
  endfunction

  // Works out the release decision for one transaction and moves the deadline on.
  function automatic res_t pace_decision(input logic act, input time_t now, input cnt_t fill);
    res_t        r;
    logic [63:0] depth, sent, lag, earliest, dl, nowx, ivl, div;
    logic        catchup;
    nowx    = 64'(now);
    ivl     = 64'(interval);
    dl      = 64'(deadline);
    depth   = (fill > QUEUE_SLOTS) ? 64'(QUEUE_SLOTS) : 64'(fill);
    sent    = 0;
    catchup = 1'b0;
    if (act == ACT_REANCHOR) begin
      dl = nowx;
    end else if (ivl == 0) begin
      sent = depth;
    end else if (depth >= 64'(catch_depth)) begin
      div     = (speedup == 0) ? 64'd1 : 64'(speedup);
      catchup = 1'b1;
      if (nowx >= dl && depth > 0) begin
        sent = 1;
        dl   = capped_sum(nowx, ivl / div);
      end
    end else if (nowx >= dl) begin
      lag      = ivl * 64'(lag_sends);
      earliest = (nowx > lag) ? nowx - lag : 64'd0;
      if (dl < earliest) dl = earliest;
      while (dl <= nowx && sent < depth) begin
        sent++;
        dl = capped_sum(dl, ivl);
      end
    end
    deadline           = time_t'(dl);
    r.send_count       = cnt_t'(sent);
    r.catchup_active   = catchup;
    r.next_deadline    = time_t'(dl);
    return r;
  endfunction

  always @(posedge clk) begin
    res_t want;
    res_t got;
    if (!rst_n) begin
      interval     = '0;
      catch_depth  = cnt_t'(8);
      speedup      = spd_t'(2);
      lag_sends    = spd_t'(2);
      deadline     = '0;
      due_results.delete();
      errors       = 0;
      results_seen = 0;
      catchup_seen = 0;
      pending     <= 0;
    end else begin
      // Results first: a transaction accepted at this edge cannot be answered yet.
      if (out_tvalid && out_tready) begin
        got.send_count     = out_tdata[CNT_W-1:0];
        got.next_deadline  = out_tdata[CNT_W +: TIME_BITS];
        got.catchup_active = out_tuser;
        results_seen++;
        if (due_results.size() == 0) begin
          errors++;
          $display("%0t: result with nothing outstanding: count %0d catchup %0b deadline %0d",
                   $time, got.send_count, got.catchup_active, got.next_deadline);
        end else begin
          want = due_results.pop_front();
          if (want.catchup_active) catchup_seen++;
          if (got.send_count !== want.send_count) begin
            errors++;
            $display("%0t: send_count expected %0d, got %0d",
                     $time, want.send_count, got.send_count);
          end
          if (got.catchup_active !== want.catchup_active) begin
            errors++;
            $display("%0t: catchup_active expected %0b, got %0b",
                     $time, want.catchup_active, got.catchup_active);
          end
          if (got.next_deadline !== want.next_deadline) begin
            errors++;
            $display("%0t: next_deadline expected %0d, got %0d",
                     $time, want.next_deadline, got.next_deadline);
          end
        end
      end
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[3:2])
          REG_PACE_INTERVAL: interval    = cfg_pwdata[IVL_W-1:0];
          REG_CATCHUP_DEPTH: catch_depth = cfg_pwdata[CNT_W-1:0];
          REG_IVL_DIVISOR:   speedup     = cfg_pwdata[SPD_W-1:0];
          REG_MAX_LAG_SENDS: lag_sends   = cfg_pwdata[SPD_W-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        due_results.push_back(pace_decision(in_tuser, in_tdata[TIME_BITS-1:0],
                                            in_tdata[TIME_BITS +: CNT_W]));
      end
      pending <= due_results.size();
    end
  end

endmodule

// ===== test/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ppace_pkg::*;

  // Longest stretch without any transaction before the run is declared hung.
  localparam int    STALL_LIMIT   = 2000;
  // Quiet cycles after the last result, more than the slowest path takes.
  localparam int    SETTLE_CYCLES = 40;
  localparam time_t LAST_TICK     = '1;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_tvalid = 1'b0;
  logic               in_tready;
  logic [TDATA_W-1:0] in_tdata = '0;     // [47:0] now_time, [53:48] queue_depth
  logic               in_tuser = 1'b0;   // [0] action
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [TDATA_W-1:0] out_tdata;         // [5:0] send_count, [53:6] next_deadline
  logic               out_tuser;         // [0] catchup_active
  logic               cfg_psel = 1'b0;
  logic               cfg_penable = 1'b0;
  logic               cfg_pwrite = 1'b0;
  logic [ADDR_W-1:0]  cfg_paddr = '0;
  logic [DATA_W-1:0]  cfg_pwdata = '0;
  logic [DATA_W-1:0]  cfg_prdata;
  logic               cfg_pready;

  int errors;
  int pending;
  int results_seen;
  int catchup_seen;
  int items_sent = 0;
  int settings_used = 0;
  int idle_cycles = 0;
  int hold_left = 0;
  int draw;
  // When set, neither side inserts gaps, so transactions run back to back.
  bit calm = 1'b0;

  packet_send_pacer DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // The monitor watches all three ports on its own and does the prediction and
  // the comparison; this module only produces traffic and gives the verdict.
  pacer_monitor u_monitor (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tuser    (out_tuser),
    .cfg_psel     (cfg_psel),
    .cfg_penable  (cfg_penable),
    .cfg_pwrite   (cfg_pwrite),
    .cfg_pready   (cfg_pready),
    .cfg_paddr    (cfg_paddr),
    .cfg_pwdata   (cfg_pwdata),
    .errors       (errors),
    .pending      (pending),
    .results_seen (results_seen),
    .catchup_seen (catchup_seen)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Result side back-pressure. After every accepted result a fresh stall of
  // random length is drawn, during which out_tready stays low; none in calm mode.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_left  <= 0;
    end else if (out_tvalid && out_tready) begin
      draw = calm ? 0 : $urandom_range(0, 12);
      hold_left  <= draw;
      out_tready <= (draw == 0);
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= (hold_left == 1);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Watchdog: any accepted transaction on any port counts as progress.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_psel && cfg_penable && cfg_pready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("Watchdog: no transaction for %0d cycles, %0d results outstanding.",
               STALL_LIMIT, pending);
      $display("tb_top: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Register write: a setup cycle, then the access cycle, then an idle cycle so
  // that a following write never lowers and raises psel within one time step.
  task automatic write_reg(input logic [1:0] idx, input data_t value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Offers one transaction after a random gap. tvalid is only dropped when a gap
  // follows, so back-to-back transactions keep it high without a glitch.
  task automatic offer_item(input logic act, input time_t now, input cnt_t depth);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 12);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {2'b00, depth, now};
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  // Holds the input side back until every outstanding result has come out.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // The block is idle once the results are out and the pipeline has had time to
  // empty; only then are the registers touched.
  task automatic settle();
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_config(input ivl_t ivl, input cnt_t cdepth, input spd_t spd,
                             input spd_t lag);
    settle();
    write_reg(REG_PACE_INTERVAL, data_t'(ivl));
    write_reg(REG_CATCHUP_DEPTH, data_t'(cdepth));
    write_reg(REG_IVL_DIVISOR, data_t'(spd));
    write_reg(REG_MAX_LAG_SENDS, data_t'(lag));
    settings_used++;
  endtask

  // One random phase under a fixed register setting. Most transactions follow a
  // believable worker: a re-anchor on waking, then timed checks whose times move
  // forward by steps scaled to the interval so that both the lag clamp and the
  // catch-up path are reached. About a tenth are unrelated noise.
  task automatic run_phase(input ivl_t ivl, input cnt_t cdepth, input spd_t spd,
                           input spd_t lag, input time_t start, input bit quiet,
                           input int count);
    time_t       cursor;
    logic [63:0] step;
    logic [63:0] ahead;
    int          pick;
    cnt_t        depth;
    load_config(ivl, cdepth, spd, lag);
    calm   = quiet;
    cursor = start;
    offer_item(ACT_REANCHOR, cursor, cnt_t'($urandom_range(0, 32)));
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 2) drain();
      if ($urandom_range(0, 99) < 6) depth = cnt_t'($urandom_range(33, 63));
      else if ($urandom_range(0, 1) != 0) depth = cnt_t'($urandom_range(0, 12));
      else depth = cnt_t'($urandom_range(0, 32));
      if (pick < 90) begin
        if (ivl == 0) begin
          step = 64'($urandom_range(0, 100));
        end else begin
          case ($urandom_range(0, 5))
            0:       step = 64'd0;
            1:       step = 64'($urandom_range(0, ivl));
            2:       step = 64'(ivl) + 64'($urandom_range(0, ivl));
            3:       step = 64'(ivl) * 64'($urandom_range(1, int'(lag) + 4))
                            + 64'($urandom_range(0, 3));
            4:       step = 64'($urandom_range(0, 7));
            default: step = 64'(ivl) * 64'($urandom_range(int'(lag) + 4, 40));
          endcase
        end
        // Time never wraps: it sticks at the top once it gets there.
        ahead  = 64'(cursor) + step;
        cursor = (ahead > 64'(LAST_TICK)) ? LAST_TICK : time_t'(ahead);
        offer_item((pick < 8) ? ACT_REANCHOR : ACT_CHECK, cursor, depth);
      end else begin
        offer_item(logic'($urandom_range(0, 1)), time_t'({$urandom, $urandom}),
                   cnt_t'($urandom_range(0, 63)));
      end
    end
    calm = 1'b0;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset setting: a zero interval drains the whole queue, and depths past the
    // queue size are cut down to it.
    settings_used++;
    offer_item(ACT_CHECK, 48'd0, cnt_t'(0));
    offer_item(ACT_CHECK, 48'd5, cnt_t'(32));
    offer_item(ACT_CHECK, 48'd6, cnt_t'(63));
    offer_item(ACT_REANCHOR, 48'd10, cnt_t'(0));

    // Interval of ten with the reset lag of two intervals and catch-up from
    // eight packets upwards.
    settle();
    write_reg(REG_PACE_INTERVAL, data_t'(10));
    settings_used++;
    offer_item(ACT_REANCHOR, 48'd100, cnt_t'(3));
    offer_item(ACT_CHECK, 48'd99, cnt_t'(3));     // deadline not reached yet
    offer_item(ACT_CHECK, 48'd100, cnt_t'(3));    // exactly on the deadline
    offer_item(ACT_CHECK, 48'd135, cnt_t'(5));    // lag clamp, several releases
    offer_item(ACT_CHECK, 48'd1000, cnt_t'(2));   // releases limited by the queue
    offer_item(ACT_CHECK, 48'd1000, cnt_t'(9));   // catch-up release
    offer_item(ACT_CHECK, 48'd1003, cnt_t'(20));  // catch-up, deadline ahead
    offer_item(ACT_REANCHOR, 48'd0, cnt_t'(0));
    offer_item(ACT_CHECK, 48'd5, cnt_t'(1));      // lag window reaches below zero

    // Largest interval, zero speedup and a zero catch-up threshold, so that even
    // an empty queue takes the catch-up path; times at the very top saturate.
    settle();
    write_reg(REG_PACE_INTERVAL, data_t'(32'hFFFF_FFFF));
    write_reg(REG_IVL_DIVISOR, data_t'(0));
    write_reg(REG_CATCHUP_DEPTH, data_t'(0));
    settings_used++;
    offer_item(ACT_REANCHOR, LAST_TICK - 48'd5, cnt_t'(0));
    offer_item(ACT_CHECK, LAST_TICK - 48'd5, cnt_t'(0));
    offer_item(ACT_CHECK, LAST_TICK - 48'd5, cnt_t'(4));
    offer_item(ACT_CHECK, LAST_TICK, cnt_t'(4));

    // Paced path with the deadline pinned at the top: every packet goes at once.
    settle();
    write_reg(REG_CATCHUP_DEPTH, data_t'(8));
    write_reg(REG_IVL_DIVISOR, data_t'(2));
    write_reg(REG_MAX_LAG_SENDS, data_t'(16));
    settings_used++;
    offer_item(ACT_REANCHOR, LAST_TICK - 48'd3, cnt_t'(7));
    offer_item(ACT_CHECK, LAST_TICK, cnt_t'(7));

    // Random phases, covering the register extremes and back-to-back stretches.
    run_phase(32'd7, 6'd8, 5'd2, 5'd2, 48'd0, 1'b0, 85);
    run_phase(32'd1, 6'd1, 5'd1, 5'd0, 48'd1000, 1'b1, 85);
    run_phase(32'hFFFF_FFFF, 6'd32, 5'd16, 5'd16, LAST_TICK - 48'h100_0000_0000, 1'b0, 85);
    run_phase(32'd100, 6'd5, 5'd3, 5'd16, 48'h0000_1234_5678, 1'b0, 85);
    run_phase(32'd0, 6'd8, 5'd2, 5'd2, 48'h7FFF_FFFF_0000, 1'b0, 85);
    run_phase(32'd13, 6'd0, 5'd0, 5'd5, 48'd500, 1'b0, 85);
    run_phase(32'h8000_0001, 6'd16, 5'd7, 5'd1, LAST_TICK - 48'h40_0000_0000, 1'b0, 85);
    run_phase(32'd50, 6'd12, 5'd16, 5'd8, 48'h8000_0000_0000, 1'b1, 85);
    run_phase(32'd3, 6'd2, 5'd5, 5'd3, 48'd20, 1'b0, 85);
    run_phase(ivl_t'($urandom_range(1, 1 << 20)), cnt_t'($urandom_range(1, 32)),
              spd_t'($urandom_range(1, 16)), spd_t'($urandom_range(0, 16)),
              time_t'($urandom), 1'b0, 85);

    settle();
    $display("Run covered %0d input transactions under %0d register settings,",
             items_sent, settings_used);
    $display("with %0d results compared, %0d of them on the catch-up path.",
             results_seen, catchup_seen);
    if (errors == 0 && pending == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
